/* rtl/kvss_pkg.sv */
package kvss_pkg;

	localparam int KEY_BITS     = 16;
	localparam int PAYLOAD_BITS = 64;
	localparam int MAX_ENTRIES  = 64;

	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
		logic                    last_in_segment;
	} in_item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]     sorted_key;
		logic [PAYLOAD_BITS-1:0] sorted_payload;
		logic                    last_out;
		logic                    overflow;
	} out_item_t;

	// one stored pair
	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
	} entry_t;

	// what the sequencer hands to the output register
	typedef struct packed {
		logic load;
		logic last;
		logic overflow;
	} emit_ctl_t;

endpackage

/* rtl/key_value_segment_sorter_top.sv */
// Channel   Dir  Handshake           Payload
// item      in   item_valid/stall    key, payload, last_in_segment
// result    out  result_valid/stall  sorted_key, sorted_payload, last_out, overflow
//
// Insertion: a pair is placed after every stored pair with a larger key has moved
//   up, one per cycle, through the store's single read and single write port.
// After the last pair, emission reads the store one entry at a time: ST_ERD issues the read, ST_ELD loads the output.
// Reset clears the fill count, the overflow flag and the sequencer; the store
//   itself is never cleared, only entries below the fill count are read.
// Stalls on the result side hold the emission; item_stall is high whenever
//   an insertion or an emission is in progress.
module key_value_segment_sorter_top #(
	parameter int MAX_ENTRIES = kvss_pkg::MAX_ENTRIES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  kvss_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output kvss_pkg::out_item_t result
);
	import kvss_pkg::*;

	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0; // waiting for a pair
	localparam logic [1:0] ST_CMP  = 2'd1; // insertion: compare, shift or place
	localparam logic [1:0] ST_ERD  = 2'd2; // emission: issue read
	localparam logic [1:0] ST_ELD  = 2'd3; // emission: load output register

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  pos_q;    // free slot the insertion is walking down
	logic [CNT_W-1:0]  idx_q;    // emission position
	logic              ovf_q;
	logic              last_q;
	entry_t            new_q;    // pair being inserted

	// sorted store, one read port (registered) and one write port
	entry_t            mem [MAX_ENTRIES];
	entry_t            rd_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;

	logic              accept;
	logic              full;
	logic              greater;
	logic              emit_last;
	logic [CNT_W-1:0]  fill_m1;
	logic [CNT_W-1:0]  pos_m2;
	logic [CNT_W-1:0]  idx_p1;
	emit_ctl_t         emit_ctl;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign full       = (fill_q == CNT_W'(MAX_ENTRIES));
	assign fill_m1    = fill_q - CNT_W'(1);
	assign pos_m2     = pos_q - CNT_W'(2);
	assign idx_p1     = idx_q + CNT_W'(1);
	assign emit_last  = (idx_p1 == fill_q);

	// rd_q holds entry pos_q-1 while in ST_CMP; strictly larger keys move up,
	// so equal keys stay ahead of the new pair (stable order)
	assign greater = (pos_q != '0) && (rd_q.key > new_q.key);

	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = fill_m1[ADDR_W-1:0];
			ST_CMP:  rd_addr = pos_m2[ADDR_W-1:0];
			ST_ERD:  rd_addr = idx_q[ADDR_W-1:0];
			default: rd_addr = '0;
		endcase
	end

	// write the shifted entry or the new pair into the free slot
	assign wr_en   = (state_q == ST_CMP);
	assign wr_addr = pos_q[ADDR_W-1:0];
	assign wr_data = greater ? rd_q : new_q;

	// read and write never target the same entry in one cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.key     <= item.key;
			new_q.payload <= item.payload;
			last_q        <= item.last_in_segment;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			pos_q   <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (full) begin
							// store full: drop the pair, remember it
							ovf_q   <= 1'b1;
							state_q <= item.last_in_segment ? ST_ERD : ST_IDLE;
						end else begin
							pos_q   <= fill_q;
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					if (greater) begin
						pos_q <= pos_q - CNT_W'(1);
					end else begin
						fill_q  <= fill_q + CNT_W'(1);
						state_q <= last_q ? ST_ERD : ST_IDLE;
					end
				end
				ST_ERD: begin
					// the register is empty or hands off at this edge
					if (!result_valid || !result_stall) begin
						state_q <= ST_ELD;
					end
				end
				ST_ELD: begin
					idx_q <= idx_p1;
					if (emit_last) begin
						fill_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ERD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign emit_ctl.load     = (state_q == ST_ELD);
	assign emit_ctl.last     = emit_last;
	assign emit_ctl.overflow = ovf_q;

	kvss_out_reg u_out_reg (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (emit_ctl),
		.entry (rd_q),
		.valid (result_valid),
		.stall (result_stall),
		.data  (result)
	);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ENTRIES))
		else $error("fill count beyond store depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (pos_q <= fill_q))
		else $error("insertion slot above fill count");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELD) |-> !result_valid)
		else $error("output register overwritten while holding a result");

	a_segment_close: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELD && emit_last) |=> (fill_q == '0 && !ovf_q))
		else $error("segment not closed after final result");
`endif

endmodule

/* rtl/kvss_out_reg.sv */
module kvss_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  kvss_pkg::emit_ctl_t ctl,
	input  kvss_pkg::entry_t   entry,
	output logic               valid,
	input  logic               stall,
	output kvss_pkg::out_item_t data
);
	import kvss_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	// load only happens while the register is empty or draining this edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q.sorted_key     <= entry.key;
			data_q.sorted_payload <= entry.payload;
			data_q.last_out       <= ctl.last;
			data_q.overflow       <= ctl.overflow;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule
